@@ design/bcxy_pkg.sv @@
// ----------------------------------------------------------------------------
// bcxy_pkg: shared types and constants for the bezier x-to-y evaluator
// Holds the payload structs, controller states and the command/status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package bcxy_pkg;

  localparam int STEPS = 16;
  localparam int SW = $clog2(STEPS + 1);   // sample index width
  localparam int RW = $clog2(STEPS + 1);   // round counter width
  localparam int TW = 17;                  // t width, Q0.16 plus one
  localparam int CW = 33;                  // control value width
  localparam logic [TW-1:0] T_ONE = 17'd65536;

  typedef struct packed {
    logic signed [31:0] query_x;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] out_handle_dx;
    logic signed [31:0] out_handle_dy;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] in_handle_dx;
    logic signed [31:0] in_handle_dy;
  } bcxy_in_t;

  typedef struct packed {
    logic signed [31:0] result_y;
    logic              exact_hit;
    logic [16:0]       found_t;
  } bcxy_out_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ROUND, ST_SAMPLE, ST_WAIT, ST_CHECK, ST_YEVAL, ST_YWAIT, ST_OUT
  } bcxy_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture input item
    logic round_init;  // new_lo/new_hi <= lo/hi
    logic eval_x;      // start x evaluation of sample k
    logic sample_upd;  // apply sample result to bounds
    logic round_end;   // lo/hi <= new_lo/new_hi
    logic pick_mid;    // t <= floor((lo+hi)/2)
    logic pick_lo;     // t <= new_lo
    logic eval_y;      // start y evaluation at t
    logic out_load;    // capture result beat
    logic [SW-1:0] k;  // sample index
  } bcxy_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic eval_done;
    logic hit;         // sample x equals query
    logic rev;         // hi < lo
    logic collapsed;   // new_lo == new_hi
  } bcxy_sts_t;

endpackage

@@ design/bcxy_ctrl.sv @@
// ----------------------------------------------------------------------------
// bcxy_ctrl: search sequencer
// Steps through rounds and samples, launches curve evaluations and
// handles the output register handshake.
// ----------------------------------------------------------------------------
module bcxy_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  bcxy_pkg::bcxy_sts_t sts,
  output bcxy_pkg::bcxy_cmd_t cmd,
  output logic              hit_set
);
  import bcxy_pkg::*;

  bcxy_state_t state, state_next;
  logic [RW-1:0] round, round_next;
  logic [SW-1:0] k, k_next;
  logic out_valid_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      round <= '0;
      k <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      round <= round_next;
      k <= k_next;
      out_valid <= out_valid_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    round_next = round;
    k_next = k;
    out_valid_next = out_valid;
    cmd = '0;
    cmd.k = k;
    hit_set = 1'b0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          round_next = '0;
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round_init = 1'b1;
        k_next = '0;
        state_next = sts.rev ? ST_CHECK : ST_SAMPLE;
      end
      ST_SAMPLE: begin
        cmd.eval_x = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (sts.eval_done) begin
          if (sts.hit) begin
            hit_set = 1'b1;
            state_next = ST_YEVAL;
          end else begin
            cmd.sample_upd = 1'b1;
            if (k == SW'(STEPS)) begin
              state_next = ST_CHECK;
            end else begin
              k_next = k + 1'b1;
              state_next = ST_SAMPLE;
            end
          end
        end
      end
      ST_CHECK: begin
        if (sts.collapsed) begin
          cmd.pick_lo = 1'b1;
          state_next = ST_YEVAL;
        end else begin
          cmd.round_end = 1'b1;
          if (round == RW'(STEPS - 1)) begin
            state_next = ST_OUT;
          end else begin
            round_next = round + 1'b1;
            state_next = ST_ROUND;
          end
        end
      end
      ST_OUT: begin
        // bounds are final here, take the midpoint
        cmd.pick_mid = 1'b1;
        state_next = ST_YEVAL;
      end
      ST_YEVAL: begin
        if (!out_valid || !out_stall) begin
          cmd.eval_y = 1'b1;
          out_valid_next = 1'b0;
          state_next = ST_YWAIT;
        end
      end
      ST_YWAIT: begin
        if (sts.eval_done) begin
          cmd.out_load = 1'b1;
          out_valid_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    // output beat taken
    if (out_valid && !out_stall && state != ST_YWAIT && state != ST_YEVAL)
      out_valid_next = 1'b0;
  end

endmodule

@@ design/bcxy_dp.sv @@
// ----------------------------------------------------------------------------
// bcxy_dp: search datapath
// Holds control values and bounds, and a shared de casteljau unit that
// does one linear step per cycle (six steps per point).
// ----------------------------------------------------------------------------
module bcxy_dp (
  input  logic                clk,
  input  bcxy_pkg::bcxy_in_t  din,
  input  bcxy_pkg::bcxy_cmd_t cmd,
  input  logic                hit_set,
  output bcxy_pkg::bcxy_sts_t sts,
  output bcxy_pkg::bcxy_out_t dout
);
  import bcxy_pkg::*;

  logic signed [31:0] qx;
  logic signed [CW-1:0] xs [4];
  logic signed [CW-1:0] ys [4];
  logic [TW-1:0] lo, hi, new_lo, new_hi, t, tk;
  logic hit;
  logic signed [CW-1:0] c [4];
  logic signed [CW-1:0] a, b, e, f, g, pt;
  logic [2:0] step;
  logic busy, done;
  logic signed [CW-1:0] lp, lq, lr;
  logic signed [CW:0] diff;
  logic signed [CW+TW:0] prod;
  logic [TW-1:0] width;
  logic [TW+SW-1:0] wk;
  logic signed [31:0] ysat;

  assign width = hi - lo;
  assign wk = width * (TW+SW)'(cmd.k);

  // de casteljau operand select
  always_comb begin
    case (step)
      3'd0: begin lp = c[0]; lq = c[1]; end
      3'd1: begin lp = c[1]; lq = c[2]; end
      3'd2: begin lp = c[2]; lq = c[3]; end
      3'd3: begin lp = a; lq = b; end
      3'd4: begin lp = b; lq = e; end
      default: begin lp = f; lq = g; end
    endcase
    diff = (CW+1)'(lq) - (CW+1)'(lp);
    prod = (CW+TW+1)'(diff) * $signed({1'b0, t});
    lr = lp + CW'(prod >>> 16);
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (cmd.load) begin
      qx <= din.query_x;
      xs[0] <= CW'(din.start_x);
      xs[1] <= CW'(din.start_x) + CW'(din.out_handle_dx);
      xs[2] <= CW'(din.end_x) + CW'(din.in_handle_dx);
      xs[3] <= CW'(din.end_x);
      ys[0] <= CW'(din.start_y);
      ys[1] <= CW'(din.start_y) + CW'(din.out_handle_dy);
      ys[2] <= CW'(din.end_y) + CW'(din.in_handle_dy);
      ys[3] <= CW'(din.end_y);
      lo <= '0;
      hi <= T_ONE;
      hit <= 1'b0;
    end
    if (cmd.round_init) begin
      new_lo <= lo;
      new_hi <= hi;
    end
    // start an evaluation
    if (cmd.eval_x) begin
      c <= xs;
      t <= lo + TW'(wk / STEPS);
      busy <= 1'b1;
      step <= '0;
    end else if (cmd.eval_y) begin
      c <= ys;
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      case (step)
        3'd0: a <= lr;
        3'd1: b <= lr;
        3'd2: e <= lr;
        3'd3: f <= lr;
        3'd4: g <= lr;
        default: pt <= lr;
      endcase
      if (step == 3'd5) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
      step <= step + 1'b1;
    end
    if (cmd.sample_upd) begin
      if (pt < CW'(qx) && t > new_lo) new_lo <= t;
      else if (pt > CW'(qx) && t < new_hi) new_hi <= t;
    end
    if (hit_set) hit <= 1'b1;
    if (cmd.round_end) begin
      lo <= new_lo;
      hi <= new_hi;
    end
    if (cmd.pick_lo) t <= new_lo;
    if (cmd.pick_mid) t <= TW'(({1'b0, lo} + {1'b0, hi}) >> 1);
  end

  assign tk = t;
  assign sts.eval_done = done;
  assign sts.hit = (pt == CW'(qx));
  assign sts.rev = hi < lo;
  assign sts.collapsed = new_lo == new_hi;

  // saturate to 32 bits
  always_comb begin
    if (pt > CW'(33'sh07FFFFFFF)) ysat = 32'sh7FFFFFFF;
    else if (pt < -CW'(33'sh080000000)) ysat = 32'sh80000000;
    else ysat = pt[31:0];
  end

  // result register, written only when the y point is done
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      dout.result_y <= ysat;
      dout.exact_hit <= hit;
      dout.found_t <= tk;
    end
  end

endmodule

@@ design/bezier_curve_x_to_y_eval_top.sv @@
// ----------------------------------------------------------------------------
// bezier_curve_x_to_y_eval_top: cubic bezier timing curve, y at given x
// Searches t where x(t) hits the query, then evaluates y(t).
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_stall/in_data) carries one curve segment and
//   a query x per beat. out channel (out_valid/out_stall/out_data) returns
//   result_y, exact_hit and found_t, one beat per input beat.
//   Each x sample is a launch state, six linear steps on the
//   shared de casteljau unit (one per cycle) and a wait state that acts on
//   the point. A round adds a setup and a check state; exact hits or
//   collapsed bounds end the search early. A midpoint pick (after a full
//   search), the y launch and the y point follow, and the controller
//   returns to idle before the next beat can be taken.
//   One item is in work at a time; in_stall is low only while idle.
//   A stalled result holds in the output register; the next item may be
//   accepted and searched but its y evaluation waits until the beat leaves.
//   Synchronous reset clears the controller and drops out_valid.
// ----------------------------------------------------------------------------
module bezier_curve_x_to_y_eval_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  bcxy_pkg::bcxy_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bcxy_pkg::bcxy_out_t out_data
);
  import bcxy_pkg::*;

  bcxy_cmd_t cmd;
  bcxy_sts_t sts;
  logic hit_set;

  bcxy_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd),
    .hit_set(hit_set)
  );

  bcxy_dp u_dp (
    .clk(clk), .din(in_data), .cmd(cmd), .hit_set(hit_set), .sts(sts),
    .dout(out_data)
  );

  // found t never exceeds one
  a_t_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.found_t <= T_ONE) else $error("found_t above one");

  // a result beat held under stall keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // no input taken while a search is running
  a_one: assert property (@(posedge clk) disable iff (rst)
    cmd.eval_x |-> in_stall) else $error("input open during search");

endmodule

@@ tb/bcxy_scoreboard.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bcxy_scoreboard: result checker for the bezier x-to-y evaluator
// Watches both channels, computes the expected y, hit flag and t for every
// accepted input beat and compares each output beat against the oldest one.
// ----------------------------------------------------------------------------
module bcxy_scoreboard (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  bcxy_pkg::bcxy_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  bcxy_pkg::bcxy_out_t out_data,
  output int                  errors,
  output int                  pending
);
  import bcxy_pkg::*;

  bcxy_out_t expected_q[$];

  // one linear step, floor of the scaled difference
  function automatic longint lerp_step(longint p, longint q, longint t);
    return p + (((q - p) * t) >>> 16);
  endfunction

  // de casteljau point of a cubic at t
  function automatic longint curve_at(longint c0, longint c1, longint c2, longint c3,
                                      longint t);
    longint a, b, e;
    a = lerp_step(c0, c1, t);
    b = lerp_step(c1, c2, t);
    e = lerp_step(c2, c3, t);
    return lerp_step(lerp_step(a, b, t), lerp_step(b, e, t), t);
  endfunction

  function automatic bcxy_out_t eval_segment(bcxy_in_t d);
    longint x0, x1, x2, x3, y0, y1, y2, y3;
    longint qx, lo, hi, t, y, nlo, nhi, w, tk, xv;
    bit hit, done;
    bcxy_out_t r;
    qx = longint'(d.query_x);
    x0 = longint'(d.start_x);
    x1 = x0 + longint'(d.out_handle_dx);
    x3 = longint'(d.end_x);
    x2 = x3 + longint'(d.in_handle_dx);
    y0 = longint'(d.start_y);
    y1 = y0 + longint'(d.out_handle_dy);
    y3 = longint'(d.end_y);
    y2 = y3 + longint'(d.in_handle_dy);
    lo = 0; hi = 65536; t = 0; hit = 0; done = 0;
    for (int rnd = 0; rnd < STEPS && !done; rnd++) begin
      nlo = lo; nhi = hi;
      // reversed bounds take no samples
      if (hi >= lo) begin
        w = hi - lo;
        for (int k = 0; k <= STEPS; k++) begin
          tk = lo + (w * k) / STEPS;
          xv = curve_at(x0, x1, x2, x3, tk);
          if (xv == qx) begin
            t = tk; hit = 1; done = 1;
            break;
          end
          if (xv < qx && tk > nlo) nlo = tk;
          else if (xv > qx && tk < nhi) nhi = tk;
        end
      end
      if (!done) begin
        // collapsed bounds end the search
        if (nlo == nhi) begin
          t = nlo; done = 1;
        end else begin
          lo = nlo; hi = nhi;
        end
      end
    end
    if (!done) t = (lo + hi) / 2;
    y = curve_at(y0, y1, y2, y3, t);
    if (y > 64'sd2147483647) y = 64'sd2147483647;
    if (y < -64'sd2147483648) y = -64'sd2147483648;
    r.result_y = y[31:0];
    r.exact_hit = hit;
    r.found_t = t[16:0];
    return r;
  endfunction

  // sample mid-cycle, where valid and stall are settled for the coming edge
  always @(negedge clk) begin
    bcxy_out_t exp_beat;
    if (rst) begin
      errors = 0;
    end else begin
      if (in_valid && !in_stall) expected_q = {expected_q, eval_segment(in_data)};
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat: %p", out_data);
        end else begin
          exp_beat = expected_q.pop_front();
          if (exp_beat.result_y !== out_data.result_y ||
              exp_beat.exact_hit !== out_data.exact_hit ||
              exp_beat.found_t !== out_data.found_t) begin
            errors++;
            if (errors <= 10)
              $display("result mismatch: expected y=%0d hit=%0d t=%0d, got y=%0d hit=%0d t=%0d",
                       exp_beat.result_y, exp_beat.exact_hit, exp_beat.found_t,
                       out_data.result_y, out_data.exact_hit, out_data.found_t);
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the bezier x-to-y evaluator
// Sends directed corner segments, then random monotonic curves with queries
// inside their x span mixed with raw random noise, under several idle and
// stall mixes including a long output hold-off. The scoreboard checks results.
// ----------------------------------------------------------------------------
module testbench;
  import bcxy_pkg::*;

  localparam int N_RANDOM = 1330;
  localparam longint CYCLE_LIMIT = 12000000;

  logic      clk = 0;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  bcxy_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  bcxy_out_t out_data;
  int        errors;
  int        pending;
  int        idle_pct = 0;
  int        stall_pct = 0;
  bit        hold_req = 0;
  longint    cycles = 0;

  bezier_curve_x_to_y_eval_top dut (.*);

  bcxy_scoreboard checker_u (.*);

  // clock
  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // output side stall, with one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else if (hold_req) begin
      hold_req = 0;
      out_stall <= 1;
      repeat (4000) @(posedge clk);
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // present one beat and hold it until taken
  task automatic send_beat(bcxy_in_t d);
    bit taken;
    in_valid <= 1;
    in_data <= d;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic bcxy_in_t raw_segment();
    bcxy_in_t d;
    d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom};
    return d;
  endfunction

  // monotonic-ish curve with a query in its x span
  function automatic bcxy_in_t wellformed_segment();
    bcxy_in_t d;
    int span;
    span = $urandom_range(1, 1 << $urandom_range(1, 24));
    d = raw_segment();
    d.start_x = $signed($urandom_range(0, 1 << 26)) - (1 << 25);
    d.end_x = d.start_x + span;
    d.out_handle_dx = $urandom_range(0, span);
    d.in_handle_dx = -$signed($urandom_range(0, span));
    d.start_y = $signed($urandom) >>> $urandom_range(0, 12);
    d.end_y = $signed($urandom) >>> $urandom_range(0, 12);
    d.out_handle_dy = $signed($urandom) >>> $urandom_range(0, 14);
    d.in_handle_dy = $signed($urandom) >>> $urandom_range(0, 14);
    d.query_x = d.start_x + $urandom_range(0, span);
    return d;
  endfunction

  initial begin
    bcxy_in_t d;
    rst = 1;
    in_valid = 0;
    in_data = '0;
    out_stall = 0;
    repeat (3) @(posedge clk);
    rst <= 0;

    // directed corners
    d = '0;
    send_beat(d);
    d = '1;
    send_beat(d);
    d = {9{32'h7fffffff}};
    send_beat(d);
    d = {9{32'h80000000}};
    send_beat(d);
    // straight line 0..1, query at the middle
    d = '0;
    d.end_x = 65536; d.end_y = 65536; d.out_handle_dx = 21845; d.in_handle_dx = -21845;
    d.query_x = 32768;
    send_beat(d);
    // query below start and above end
    d.query_x = -5;
    send_beat(d);
    d.query_x = 70000;
    send_beat(d);
    // non-monotonic x: handles fold back, bounds can cross
    d.out_handle_dx = 32'sh00300000; d.in_handle_dx = -32'sh00300000;
    d.query_x = 30000;
    send_beat(d);
    d.out_handle_dx = -32'sh00300000; d.in_handle_dx = 32'sh00300000;
    send_beat(d);
    // y overflow both ways
    d = wellformed_segment();
    d.start_y = 32'h7fffffff; d.out_handle_dy = 32'h7fffffff;
    d.end_y = 32'h7fffffff; d.in_handle_dy = 32'h7fffffff;
    send_beat(d);
    d.start_y = 32'h80000000; d.out_handle_dy = 32'h80000000;
    d.end_y = 32'h80000000; d.in_handle_dy = 32'h80000000;
    send_beat(d);
    // tiny span, bounds collapse quickly
    d = wellformed_segment();
    d.end_x = d.start_x + 1; d.out_handle_dx = 0; d.in_handle_dx = 0;
    d.query_x = d.start_x;
    send_beat(d);
    d.query_x = d.end_x;
    send_beat(d);
    // long output hold-off with input kept busy
    hold_req = 1;
    for (int i = 0; i < 6; i++) send_beat(wellformed_segment());

    // random phases: none, sender idle, receiver stalling, both
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 80 : (ph == 3) ? 28 : 0;
      stall_pct = (ph == 2) ? 80 : (ph == 3) ? 28 : 0;
      for (int i = 0; i < N_RANDOM / 4; i++) begin
        if ($urandom_range(99) < 85) send_beat(wellformed_segment());
        else send_beat(raw_segment());
      end
    end
    in_valid <= 0;

    // drain
    while (pending != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

@@ filelist.f @@
design/bcxy_pkg.sv
design/bcxy_ctrl.sv
design/bcxy_dp.sv
design/bezier_curve_x_to_y_eval_top.sv
tb/bcxy_scoreboard.sv
tb/testbench.sv
